@@ hdl/qsa_pkg.sv @@
// Package for the quadratic sieve accumulator: field widths, register codes,
// operation codes, controller states and the structs passed between modules.
// No dependencies.
package qsa_pkg;

   localparam int SIEVE_DEPTH_DEF = 65536;
   localparam int SCAN_BYTES_DEF  = 8;

   localparam int MODE_W      = 2;
   localparam int PRIME_W     = 16;
   localparam int LOG_W       = 8;
   localparam int ROOT_W      = 16;
   localparam int WORD_W      = 13;
   localparam int HIT_W       = 8;
   localparam int BYTE_W      = 8;
   localparam int CFG_LEN_W   = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam logic [BYTE_W-1:0]    COARSE_MASK  = 8'hC0;
   localparam logic [CFG_LEN_W-1:0] LEN_RESET    = 17'd65536;
   localparam logic [BYTE_W-1:0]    FILL_RESET   = 8'd0;
   localparam logic [BYTE_W-1:0]    THRESH_RESET = 8'd64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SIEVE_LENGTH     = 2'd0,
      CSR_FILL_VALUE       = 2'd1,
      CSR_REPORT_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_SIEVE = 2'd1,
      MODE_SCAN  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SIEVE_RD,
      ST_SIEVE_WR,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_SCAN_DONE
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [PRIME_W-1:0] prime;
      logic [LOG_W-1:0]   log_size;
      logic [ROOT_W-1:0]  root_one;
      logic [ROOT_W-1:0]  root_two;
      logic [WORD_W-1:0]  scan_word;
   } qsa_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] fill_value;
      logic [BYTE_W-1:0] report_threshold;
   } qsa_cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0] word_index;
      logic [HIT_W-1:0]  hit_mask;
   } qsa_rsp_type;

endpackage

@@ hdl/qsa_if.sv @@
// Valid/ready channel interfaces for the request and response words.
// Depends on qsa_pkg.
interface qsa_req_if;
   import qsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [PRIME_W-1:0]  prime;
   logic [LOG_W-1:0]    log_size;
   logic [ROOT_W-1:0]   root_one;
   logic [ROOT_W-1:0]   root_two;
   logic [WORD_W-1:0]   scan_word;

   modport source (output valid, mode, prime, log_size, root_one, root_two, scan_word,
                   input ready);
   modport sink (input valid, mode, prime, log_size, root_one, root_two, scan_word,
                 output ready);
endinterface

interface qsa_rsp_if;
   import qsa_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word_index;
   logic [HIT_W-1:0]  hit_mask;

   modport source (output valid, word_index, hit_mask, input ready);
   modport sink (input valid, word_index, hit_mask, output ready);
endinterface

@@ hdl/qsa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module qsa_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/qsa_seq.sv @@
// Controller of the accumulator: clear sweep, read-modify-write of sieve hits
// and the byte-by-byte scan of one word. Depends on qsa_pkg; drives qsa_ram.
module qsa_seq #(
   parameter  int SIEVE_DEPTH = qsa_pkg::SIEVE_DEPTH_DEF,
   parameter  int SCAN_BYTES  = qsa_pkg::SCAN_BYTES_DEF,
   localparam int ADDR_W      = $clog2(SIEVE_DEPTH),
   localparam int POS_W       =
      ((ADDR_W + 1 > qsa_pkg::CFG_LEN_W) ? ADDR_W + 1 : qsa_pkg::CFG_LEN_W) + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  qsa_pkg::qsa_req_type       req_item,
   input  qsa_pkg::qsa_cfg_type       cfg,
   input  logic [POS_W-1:0]           eff_len,
   input  logic                       rsp_free,
   output logic                       rsp_load,
   output qsa_pkg::qsa_rsp_type       rsp_item,
   output logic                       ram_wr_en,
   output logic [ADDR_W-1:0]          ram_wr_addr,
   output logic [qsa_pkg::BYTE_W-1:0] ram_wr_data,
   output logic                       ram_rd_en,
   output logic [ADDR_W-1:0]          ram_rd_addr,
   input  logic [qsa_pkg::BYTE_W-1:0] ram_rd_data
);
   import qsa_pkg::*;

   localparam int CNT_W = $clog2(SCAN_BYTES);

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [PRIME_W-1:0] stride_ff, stride_in;
   logic [ROOT_W-1:0]  root2_ff, root2_in;
   logic [LOG_W-1:0]   log_ff, log_in;
   logic               second_ff, second_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [HIT_W-1:0]   mask_ff, mask_in;
   logic               coarse_ff, coarse_in;
   logic               ok_ff, ok_in;
   logic               accept;
   logic               in_range;

   assign accept   = req_valid & req_ready;
   assign in_range = pos_ff < eff_len;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.mode)
                  MODE_CLEAR: state_in = ST_CLEAR;
                  MODE_SIEVE: begin
                     if (req_item.root_two != '0 && req_item.prime != '0) begin
                        state_in = ST_SIEVE_RD;
                     end
                  end
                  MODE_SCAN:  state_in = ST_SCAN_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (!in_range) begin
               state_in = ST_IDLE;
            end
         end
         ST_SIEVE_RD: begin
            if (in_range) begin
               state_in = ST_SIEVE_WR;
            end else if (second_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_SIEVE_WR:  state_in = ST_SIEVE_RD;
         ST_SCAN_RD:   state_in = ST_SCAN_EVAL;
         ST_SCAN_EVAL: begin
            if (cnt_ff == CNT_W'(SCAN_BYTES - 1)) begin
               state_in = ST_SCAN_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pos_in    = pos_ff;
      stride_in = stride_ff;
      root2_in  = root2_ff;
      log_in    = log_ff;
      second_in = second_ff;
      cnt_in    = cnt_ff;
      word_in   = word_ff;
      mask_in   = mask_ff;
      coarse_in = coarse_ff;
      ok_in     = ok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               stride_in = req_item.prime;
               root2_in  = req_item.root_two;
               log_in    = req_item.log_size;
               second_in = 1'b0;
               cnt_in    = '0;
               word_in   = req_item.scan_word;
               mask_in   = '0;
               coarse_in = 1'b0;
               case (req_item.mode)
                  MODE_CLEAR: pos_in = '0;
                  MODE_SIEVE: pos_in = POS_W'(req_item.root_one);
                  MODE_SCAN:  pos_in = POS_W'(req_item.scan_word) * POS_W'(SCAN_BYTES);
                  default:    pos_in = pos_ff;
               endcase
            end
         end
         ST_CLEAR: begin
            if (in_range) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         ST_SIEVE_RD: begin
            if (!in_range && !second_ff) begin
               pos_in    = POS_W'(root2_ff);
               second_in = 1'b1;
            end
         end
         ST_SIEVE_WR: pos_in = pos_ff + POS_W'(stride_ff);
         ST_SCAN_RD:  ok_in  = in_range;
         ST_SCAN_EVAL: begin
            if (ok_ff) begin
               coarse_in = coarse_ff | (|(ram_rd_data & COARSE_MASK));
               for (int b = 0; b < SCAN_BYTES; b++) begin
                  if (cnt_ff == CNT_W'(b)) begin
                     mask_in[b] = ram_rd_data > cfg.report_threshold;
                  end
               end
            end
            pos_in = pos_ff + POS_W'(1);
            cnt_in = cnt_ff + CNT_W'(1);
         end
         default: pos_in = pos_ff;
      endcase
   end

   always_comb begin
      req_ready   = state_ff == ST_IDLE;
      ram_wr_en   = (state_ff == ST_CLEAR && in_range) || state_ff == ST_SIEVE_WR;
      ram_wr_addr = pos_ff[ADDR_W-1:0];
      ram_wr_data = (state_ff == ST_CLEAR) ? cfg.fill_value : ram_rd_data + log_ff;
      ram_rd_en   = (state_ff == ST_SIEVE_RD || state_ff == ST_SCAN_RD) && in_range;
      ram_rd_addr = pos_ff[ADDR_W-1:0];
      rsp_load    = state_ff == ST_SCAN_DONE && rsp_free;
      rsp_item.word_index = word_ff;
      rsp_item.hit_mask   = coarse_ff ? mask_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pos_ff    <= pos_in;
      stride_ff <= stride_in;
      root2_ff  <= root2_in;
      log_ff    <= log_in;
      second_ff <= second_in;
      cnt_ff    <= cnt_in;
      word_ff   <= word_in;
      mask_ff   <= mask_in;
      coarse_ff <= coarse_in;
      ok_ff     <= ok_in;
   end

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("RAM read and write issued in the same cycle");

   a_read_then_use: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> (state_ff == ST_SIEVE_WR || state_ff == ST_SCAN_EVAL))
      else $error("RAM read data not consumed in the following cycle");

   a_rmw_same_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIEVE_WR) |-> (ram_wr_addr == $past(ram_rd_addr)))
      else $error("sieve write-back goes to a different entry than was read");

endmodule

@@ hdl/quadratic_sieve_accumulator_core.sv @@
// Log-sieving accumulator for a quadratic sieve: a byte store in one RAM that is
// cleared, sieved one prime at a time and scanned one word at a time.
// Depends on qsa_pkg, qsa_if, qsa_ram and qsa_seq.
//
// One request word is handled at a time. A clear makes one RAM write per
// position of the effective sieve length. A sieve word handles each hit as a
// read, then a write back of the sum, since every hit is a read-modify-write
// through the single RAM. A scan word reads and evaluates its bytes one by one
// before its response is placed in the output register; a new request word is
// taken while that response waits to be collected. The effective length is the
// smaller of sieve_length and SIEVE_DEPTH. Store contents are undefined after
// reset until a clear has been issued.
module quadratic_sieve_accumulator_core #(
   parameter int SIEVE_DEPTH = qsa_pkg::SIEVE_DEPTH_DEF,
   parameter int SCAN_BYTES  = qsa_pkg::SCAN_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   qsa_req_if.sink                         req_if,
   qsa_rsp_if.source                       rsp_if,
   input  logic                            csr_write_en,
   input  logic [qsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qsa_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import qsa_pkg::*;

   localparam int ADDR_W = $clog2(SIEVE_DEPTH);
   localparam int POS_W  = ((ADDR_W + 1 > CFG_LEN_W) ? ADDR_W + 1 : CFG_LEN_W) + 1;

   logic [CFG_LEN_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0]    fill_ff, fill_in;
   logic [BYTE_W-1:0]    thresh_ff, thresh_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   qsa_rsp_type          rsp_data_ff, rsp_data_in;

   logic [POS_W-1:0]  eff_len;
   qsa_cfg_type       cfg;
   qsa_req_type       req_item;
   qsa_rsp_type       rsp_item;
   logic              rsp_free;
   logic              rsp_load;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   always_comb begin
      len_in    = len_ff;
      fill_in   = fill_ff;
      thresh_in = thresh_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SIEVE_LENGTH:     len_in    = csr_write_data;
            CSR_FILL_VALUE:       fill_in   = csr_write_data[BYTE_W-1:0];
            CSR_REPORT_THRESHOLD: thresh_in = csr_write_data[BYTE_W-1:0];
            default:              len_in    = len_ff;
         endcase
      end
   end

   assign eff_len = (POS_W'(len_ff) > POS_W'(SIEVE_DEPTH)) ? POS_W'(SIEVE_DEPTH)
                                                           : POS_W'(len_ff);

   assign cfg.fill_value       = fill_ff;
   assign cfg.report_threshold = thresh_ff;

   assign req_item.mode      = req_if.mode;
   assign req_item.prime     = req_if.prime;
   assign req_item.log_size  = req_if.log_size;
   assign req_item.root_one  = req_if.root_one;
   assign req_item.root_two  = req_if.root_two;
   assign req_item.scan_word = req_if.scan_word;

   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_data_in  = rsp_load ? rsp_item : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_RESET;
         fill_ff      <= FILL_RESET;
         thresh_ff    <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.word_index = rsp_data_ff.word_index;
   assign rsp_if.hit_mask   = rsp_data_ff.hit_mask;

   qsa_seq #(
      .SIEVE_DEPTH (SIEVE_DEPTH),
      .SCAN_BYTES  (SCAN_BYTES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_item    (req_item),
      .cfg         (cfg),
      .eff_len     (eff_len),
      .rsp_free    (rsp_free),
      .rsp_load    (rsp_load),
      .rsp_item    (rsp_item),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   qsa_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SIEVE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
